// File: hw/rtl/qs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qs_pkg
// Shared constants, tables and types of the quaternion slerp pipeline.
// ----------------------------------------------------------------------------
package qs_pkg;

    // component and blend formats
    localparam int FRAC_BITS    = 14;
    localparam int T_BITS       = 14;
    localparam int T_ONE        = 1 << T_BITS;
    localparam int IQ           = 30;
    localparam int D30_SHIFT    = IQ - 2 * FRAC_BITS;
    localparam int LIN_LIMIT    = (1 << (2 * FRAC_BITS)) - (1 << FRAC_BITS);

    // iterative units
    localparam int CORDIC_STEPS = 31;
    localparam int SQRT_STEPS   = 31;
    localparam int Q_BITS       = 38;
    localparam int CORDIC_GAIN  = 652032874;

    // side info delay: rad stage, sqrt, angle, scale, sine, divide
    localparam int SIDE_N = 2 + SQRT_STEPS + CORDIC_STEPS + 1 + CORDIC_STEPS + Q_BITS;
    localparam int ANG_IDX = 1 + SQRT_STEPS + CORDIC_STEPS;
    localparam int SIN_IDX = ANG_IDX + 1 + CORDIC_STEPS;

    // atan(2^-i) in Q30 radians
    localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
        30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
        30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1
    };

    typedef logic signed [33:0] cordic_t;

    // item fields that ride along the trig path
    typedef struct packed {
        logic [3:0][15:0] a;
        logic [3:0][15:0] b;
        logic [14:0]      t;
        logic             lin;
        logic             neg;
    } side_t;

endpackage

// File: hw/rtl/quaternion_slerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_slerp
// Fixed-point short-arc slerp of two Q2.14 quaternions by a Q1.14 blend.
// ----------------------------------------------------------------------------
// channel  dir  fields (low bit up)
// s_*      in   a_x a_y a_z a_w b_x b_y b_z b_w blend, 144-bit tdata
// m_*      out  out_x out_y out_z out_w, 64-bit tdata
//
// One item per cycle sustained while the output is not stalled; the depth is
// set by the sqrt, angle CORDIC, sine CORDIC and 38-step divider chains, one step per stage.
// Reset clears only the valid bits; no clearing pass.
// A stall at the output freezes the whole pipeline; s_tready follows.
// ----------------------------------------------------------------------------
module quaternion_slerp
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // a_x a_y a_z a_w b_x b_y b_z b_w blend, pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata    // out_x out_y out_z out_w
);

    localparam int SN = qs_pkg::SIDE_N;
    localparam int CS = qs_pkg::CORDIC_STEPS;
    localparam int SQ = qs_pkg::SQRT_STEPS;
    localparam int QB = qs_pkg::Q_BITS;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------- stage 1: component products, blend clamp
    logic                vld1_reg;
    logic signed [31:0]  p_reg [4];
    qs_pkg::side_t       side1_reg;
    logic [14:0]         t_in;
    logic [14:0]         t_clamp;

    assign t_in    = s_tdata[142:128];
    assign t_clamp = (t_in > 15'(qs_pkg::T_ONE)) ? 15'(qs_pkg::T_ONE) : t_in;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                p_reg[k] <= $signed(s_tdata[16*k +: 16]) * $signed(s_tdata[64+16*k +: 16]);
                side1_reg.a[k] <= s_tdata[16*k +: 16];
                side1_reg.b[k] <= s_tdata[64+16*k +: 16];
            end
            side1_reg.t   <= t_clamp;
            side1_reg.lin <= 1'b0;
            side1_reg.neg <= 1'b0;
        end
    end

    // ---------------- stage 2: dot product, sign, linear test
    logic signed [33:0] dsum;
    logic               dneg;
    logic [32:0]        absd;
    logic [29:0]        d30;
    logic [29:0]        d30_r2;
    qs_pkg::side_t      side_s2;
    qs_pkg::side_t      side_dly [SN];
    logic               vld_reg  [SN];

    always_comb
    begin
        dsum = 34'(p_reg[0]) + 34'(p_reg[1]) + 34'(p_reg[2]) + 34'(p_reg[3]);
        dneg = dsum < 0;
        absd = 33'(dneg ? -dsum : dsum);
        d30  = 30'(absd << qs_pkg::D30_SHIFT);
        side_s2     = side1_reg;
        side_s2.neg = dneg;
        side_s2.lin = absd > 33'(qs_pkg::LIN_LIMIT);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d30_r2      <= d30;
            side_dly[0] <= side_s2;
            for (int k = 1; k < SN; k++)
                side_dly[k] <= side_dly[k-1];
        end
    end

    // ---------------- stage 3: radicand 1 - d^2 in Q60
    logic [60:0] rad_reg;
    logic [29:0] d30_r3;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= (61'(1) << 60) - 61'(d30_r2) * 61'(d30_r2);
            d30_r3  <= d30_r2;
        end
    end

    // ---------------- floor square root, one bit pair per stage
    logic [60:0] sn_reg [SQ];
    logic [60:0] sr_reg [SQ];
    logic [29:0] sd_reg [SQ];

    genvar k;
    generate
        for (k = 0; k < SQ; k++)
        begin : g_sqrt
            logic [60:0] n_prev, r_prev, trial;
            logic [29:0] d_prev;
            if (k == 0)
            begin : g_first
                assign n_prev = rad_reg;
                assign r_prev = '0;
                assign d_prev = d30_r3;
            end
            else
            begin : g_next
                assign n_prev = sn_reg[k-1];
                assign r_prev = sr_reg[k-1];
                assign d_prev = sd_reg[k-1];
            end
            assign trial = r_prev + (61'(1) << (60 - 2 * k));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sd_reg[k] <= d_prev;
                    if (n_prev >= trial)
                    begin
                        sn_reg[k] <= n_prev - trial;
                        sr_reg[k] <= (r_prev >> 1) + (61'(1) << (60 - 2 * k));
                    end
                    else
                    begin
                        sn_reg[k] <= n_prev;
                        sr_reg[k] <= r_prev >> 1;
                    end
                end
            end
        end
    endgenerate

    // ---------------- vectoring CORDIC: theta = atan2(s, d)
    qs_pkg::cordic_t ax_reg [CS];
    qs_pkg::cordic_t ay_reg [CS];
    qs_pkg::cordic_t az_reg [CS];
    logic [30:0]     as_reg [CS];

    generate
        for (k = 0; k < CS; k++)
        begin : g_angle
            qs_pkg::cordic_t x_prev, y_prev, z_prev, at;
            logic [30:0]     s_prev;
            if (k == 0)
            begin : g_first
                assign x_prev = $signed({4'b0000, sd_reg[SQ-1]});
                assign y_prev = $signed({3'b000, sr_reg[SQ-1][30:0]});
                assign z_prev = '0;
                assign s_prev = sr_reg[SQ-1][30:0];
            end
            else
            begin : g_next
                assign x_prev = ax_reg[k-1];
                assign y_prev = ay_reg[k-1];
                assign z_prev = az_reg[k-1];
                assign s_prev = as_reg[k-1];
            end
            assign at = $signed({4'b0000, qs_pkg::ATAN_Q30[k]});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    as_reg[k] <= s_prev;
                    if (y_prev > 0)
                    begin
                        ax_reg[k] <= x_prev + (y_prev >>> k);
                        ay_reg[k] <= y_prev - (x_prev >>> k);
                        az_reg[k] <= z_prev + at;
                    end
                    else
                    begin
                        ax_reg[k] <= x_prev - (y_prev >>> k);
                        ay_reg[k] <= y_prev + (x_prev >>> k);
                        az_reg[k] <= z_prev - at;
                    end
                end
            end
        end
    endgenerate

    // ---------------- scale angle by t and 1-t
    logic [31:0] th32;
    logic [14:0] tc_sc;
    logic [46:0] prod_a, prod_b;
    logic [31:0] ta_reg, tb_reg;
    logic [30:0] s_sc_reg;

    assign th32   = az_reg[CS-1][31:0];
    assign tc_sc  = 15'(qs_pkg::T_ONE) - side_dly[qs_pkg::ANG_IDX].t;
    assign prod_a = 47'(th32) * 47'(tc_sc);
    assign prod_b = 47'(th32) * 47'(side_dly[qs_pkg::ANG_IDX].t);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ta_reg   <= 32'(prod_a >> qs_pkg::T_BITS);
            tb_reg   <= 32'(prod_b >> qs_pkg::T_BITS);
            s_sc_reg <= as_reg[CS-1];
        end
    end

    // ---------------- two sine lanes, s delayed alongside
    qs_pkg::cordic_t sin_a, sin_b;
    logic [30:0]     s_dly [CS];

    qs_cordic_sin u_sin_a
    (
        .clk     (clk),
        .en      (en),
        .z_in    ($signed({2'b00, ta_reg})),
        .sin_out (sin_a)
    );

    qs_cordic_sin u_sin_b
    (
        .clk     (clk),
        .en      (en),
        .z_in    ($signed({2'b00, tb_reg})),
        .sin_out (sin_b)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_dly[0] <= s_sc_reg;
            for (int i = 1; i < CS; i++)
                s_dly[i] <= s_dly[i-1];
        end
    end

    // ---------------- restoring divide |sin| << 30 / s, one quotient bit per stage
    logic [31:0]     rem_reg [2][QB];
    logic [QB-1:0]   q_reg   [2][QB];
    logic [32:0]     mag_reg [2][QB];
    logic            sgn_reg [2][QB];
    logic [30:0]     ds_reg  [QB];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ds_reg[0] <= s_dly[CS-1];
            for (int i = 1; i < QB; i++)
                ds_reg[i] <= ds_reg[i-1];
        end
    end

    genvar j;
    generate
        for (j = 0; j < 2; j++)
        begin : g_lane
            qs_pkg::cordic_t num;
            assign num = (j == 0) ? sin_a : sin_b;
            for (k = 0; k < QB; k++)
            begin : g_div
                logic [31:0]   rem_prev;
                logic [QB-1:0] q_prev;
                logic [32:0]   mag_prev;
                logic          sgn_prev;
                logic [30:0]   s_prev;
                logic          nbit;
                logic [32:0]   trial;
                if (k == 0)
                begin : g_first
                    assign mag_prev = 33'(num < 0 ? -num : num);
                    assign sgn_prev = num < 0;
                    assign rem_prev = 32'(mag_prev >> (QB - qs_pkg::IQ));
                    assign q_prev   = '0;
                    assign s_prev   = s_dly[CS-1];
                end
                else
                begin : g_next
                    assign mag_prev = mag_reg[j][k-1];
                    assign sgn_prev = sgn_reg[j][k-1];
                    assign rem_prev = rem_reg[j][k-1];
                    assign q_prev   = q_reg[j][k-1];
                    assign s_prev   = ds_reg[k-1];
                end
                // dividend bit below the remainder; low IQ bits are zero
                if (QB - 1 - k >= qs_pkg::IQ)
                begin : g_nb
                    assign nbit = mag_prev[QB - 1 - k - qs_pkg::IQ];
                end
                else
                begin : g_nz
                    assign nbit = 1'b0;
                end
                assign trial = {rem_prev, nbit};

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        mag_reg[j][k] <= mag_prev;
                        sgn_reg[j][k] <= sgn_prev;
                        if (trial >= 33'(s_prev))
                        begin
                            rem_reg[j][k] <= 32'(trial - 33'(s_prev));
                            q_reg[j][k]   <= {q_prev[QB-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg[j][k] <= 32'(trial);
                            q_reg[j][k]   <= {q_prev[QB-2:0], 1'b0};
                        end
                    end
                end
            end
        end
    endgenerate

    // ---------------- weight select and short-path sign
    qs_pkg::side_t      side_w;
    logic [14:0]        tc_w;
    logic signed [39:0] w1, w2;
    logic signed [39:0] w1_reg, w2_reg;
    qs_pkg::side_t      side_wr;
    logic               vld_w_reg;

    assign side_w = side_dly[SN-1];
    assign tc_w   = 15'(qs_pkg::T_ONE) - side_w.t;

    always_comb
    begin
        if (side_w.lin)
        begin
            w1 = $signed(40'(tc_w) << (qs_pkg::IQ - qs_pkg::T_BITS));
            w2 = $signed(40'(side_w.t) << (qs_pkg::IQ - qs_pkg::T_BITS));
        end
        else
        begin
            w1 = sgn_reg[0][QB-1] ? -$signed(40'(q_reg[0][QB-1])) : $signed(40'(q_reg[0][QB-1]));
            w2 = sgn_reg[1][QB-1] ? -$signed(40'(q_reg[1][QB-1])) : $signed(40'(q_reg[1][QB-1]));
        end
        if (side_w.neg)
            w2 = -w2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg  <= w1;
            w2_reg  <= w2;
            side_wr <= side_w;
        end
    end

    // ---------------- weighted products
    logic signed [55:0] pa_reg [4];
    logic signed [55:0] pb_reg [4];
    logic               vld_p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pa_reg[i] <= w1_reg * $signed(side_wr.a[i]);
                pb_reg[i] <= w2_reg * $signed(side_wr.b[i]);
            end
        end
    end

    // ---------------- round half up, saturate, output register
    logic signed [56:0] osum [4];
    logic signed [26:0] oval [4];
    logic [15:0]        osat [4];
    logic [63:0]        out_reg;
    logic               out_vld_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            osum[i] = 57'(pa_reg[i]) + 57'(pb_reg[i]) + 57'(64'sd1 << (qs_pkg::IQ - 1));
            oval[i] = 27'(osum[i] >>> qs_pkg::IQ);
            if (oval[i] > 27'sd32767)
                osat[i] = 16'h7FFF;
            else if (oval[i] < -27'sd32768)
                osat[i] = 16'h8000;
            else
                osat[i] = oval[i][15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= {osat[3], osat[2], osat[1], osat[0]};
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    // ---------------- valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg    <= 1'b0;
            vld_w_reg   <= 1'b0;
            vld_p_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < SN; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg   <= s_tvalid;
            vld_reg[0] <= vld1_reg;
            for (int i = 1; i < SN; i++)
                vld_reg[i] <= vld_reg[i-1];
            vld_w_reg   <= vld_reg[SN-1];
            vld_p_reg   <= vld_w_reg;
            out_vld_reg <= vld_p_reg;
        end
    end

    // ---------------- assertions
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg[0]) && $stable(vld_reg[SN-1]) && $stable(vld_p_reg))
        else $error("pipeline moved during stall");

    a_theta_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[qs_pkg::ANG_IDX] && !side_dly[qs_pkg::ANG_IDX].lin
        |-> (az_reg[CS-1] > 0) && (az_reg[CS-1][33:31] == 3'b000))
        else $error("angle out of first quadrant");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[qs_pkg::SIN_IDX] && !side_dly[qs_pkg::SIN_IDX].lin |-> s_dly[CS-1] != 0)
        else $error("zero divisor on trig path");

endmodule

// File: hw/rtl/qs_cordic_sin.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qs_cordic_sin
// Rotation-mode CORDIC sine, one iteration per register stage, Q30 in/out.
// ----------------------------------------------------------------------------
module qs_cordic_sin
(
    input  logic            clk,
    input  logic            en,
    input  qs_pkg::cordic_t z_in,
    output qs_pkg::cordic_t sin_out
);

    qs_pkg::cordic_t x_reg [qs_pkg::CORDIC_STEPS];
    qs_pkg::cordic_t y_reg [qs_pkg::CORDIC_STEPS];
    qs_pkg::cordic_t z_reg [qs_pkg::CORDIC_STEPS];

    genvar k;
    generate
        for (k = 0; k < qs_pkg::CORDIC_STEPS; k++)
        begin : g_step
            qs_pkg::cordic_t x_prev, y_prev, z_prev, at;
            if (k == 0)
            begin : g_first
                assign x_prev = qs_pkg::cordic_t'(qs_pkg::CORDIC_GAIN);
                assign y_prev = '0;
                assign z_prev = z_in;
            end
            else
            begin : g_next
                assign x_prev = x_reg[k-1];
                assign y_prev = y_reg[k-1];
                assign z_prev = z_reg[k-1];
            end
            assign at = $signed({4'b0000, qs_pkg::ATAN_Q30[k]});

            // rotate toward zero residual angle
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (z_prev >= 0)
                    begin
                        x_reg[k] <= x_prev - (y_prev >>> k);
                        y_reg[k] <= y_prev + (x_prev >>> k);
                        z_reg[k] <= z_prev - at;
                    end
                    else
                    begin
                        x_reg[k] <= x_prev + (y_prev >>> k);
                        y_reg[k] <= y_prev - (x_prev >>> k);
                        z_reg[k] <= z_prev + at;
                    end
                end
            end
        end
    endgenerate

    assign sin_out = y_reg[qs_pkg::CORDIC_STEPS-1];

endmodule
